### rtl/a2sc_pkg.sv
package a2sc_pkg;

  localparam int FILL_W    = 6;
  localparam int LEN_BYTES = 4;
  localparam int CQ_DEPTH  = 4;
  localparam int CQ_AW     = 2;

  localparam logic [4:0] IDR_TYPE = 5'd5;

  localparam logic [1:0] KIND_STREAM = 2'd0;
  localparam logic [1:0] KIND_SETUP  = 2'd1;
  localparam logic [1:0] KIND_PERR   = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_TRUNC    = 3'd1;
  localparam logic [2:0] ERR_NAL_OVR  = 3'd2;
  localparam logic [2:0] ERR_UNIT_OVR = 3'd3;
  localparam logic [2:0] ERR_STORE    = 3'd4;

  localparam logic [2:0] CMD_BYTE   = 3'd0;
  localparam logic [2:0] CMD_SC     = 3'd1;
  localparam logic [2:0] CMD_NAL    = 3'd2;
  localparam logic [2:0] CMD_REPORT = 3'd3;
  localparam logic [2:0] CMD_PERR   = 3'd4;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       end_of_packet;
    logic [2:0] error_code;
    logic       sps_missing;
    logic       pps_missing;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [7:0]        data;
    logic              long_sc;
    logic              eop;
    logic [FILL_W-1:0] fill;
    logic [2:0]        err;
    logic              sm;
    logic              pm;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [FILL_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

### rtl/a2sc_front.sv
module a2sc_front #(
  parameter int PSTORE_BYTES = 56
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  a2sc_pkg::in_item_t  in_item,
  output logic                full,
  input  logic                q_full,
  output logic                q_push,
  output a2sc_pkg::cmd_t      q_cmd,
  input  logic                burst_done,
  output a2sc_pkg::store_wr_t st_wr
);
  import a2sc_pkg::*;

  localparam logic [2:0] RP_SKIP   = 3'd0;
  localparam logic [2:0] RP_SPSCNT = 3'd1;
  localparam logic [2:0] RP_LENHI  = 3'd2;
  localparam logic [2:0] RP_LENLO  = 3'd3;
  localparam logic [2:0] RP_PPSCNT = 3'd4;
  localparam logic [2:0] RP_BODY   = 3'd5;
  localparam logic [2:0] RP_DONE   = 3'd6;
  localparam logic [2:0] RP_FAIL   = 3'd7;

  localparam logic [1:0] PP_LEN  = 2'd0;
  localparam logic [1:0] PP_HEAD = 2'd1;
  localparam logic [1:0] PP_BODY = 2'd2;

  logic [2:0]        rec_phase_r, rec_phase_nxt;
  logic [2:0]        rec_pos_r, rec_pos_nxt;
  logic [7:0]        unit_cnt_r, unit_cnt_nxt;
  logic [15:0]       unit_left_r, unit_left_nxt;
  logic              sps_r, sps_nxt;
  logic              pps_r, pps_nxt;
  logic [2:0]        rec_err_r, rec_err_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [2:0]        wr_left_r, wr_left_nxt;
  logic [1:0]        pkt_phase_r, pkt_phase_nxt;
  logic [1:0]        prefix_r, prefix_nxt;
  logic [31:0]       nal_rem_r, nal_rem_nxt;
  logic              first_r, first_nxt;
  logic              burst_pend_r, burst_pend_nxt;

  logic              acc;
  logic [7:0]        b;
  logic [15:0]       lv;
  logic [16:0]       need;
  logic [7:0]        cnt_dec;
  logic [2:0]        fin_phase;
  logic [15:0]       left_dec;
  logic [31:0]       nal_shift;
  logic [31:0]       nal_dec;
  logic [2:0]        errc;
  logic              wr_start;

  assign full = !rst_n || (wr_left_r != 3'd0) || q_full || burst_pend_r;
  assign acc  = push && !full;
  assign b    = in_item.data_byte;

  assign lv        = {unit_left_r[15:8], b};
  assign need      = {{(17 - FILL_W){1'b0}}, fill_r} + 17'd4 + {1'b0, lv};
  assign cnt_dec   = unit_cnt_r - 8'd1;
  assign fin_phase = (cnt_dec != 8'd0) ? RP_LENHI :
                     ((rec_pos_r != 3'd0) ? RP_DONE : RP_PPSCNT);
  assign left_dec  = unit_left_r - 16'd1;
  assign nal_shift = {nal_rem_r[23:0], b};
  assign nal_dec   = nal_rem_r - 32'd1;

  always_comb begin
    rec_phase_nxt  = rec_phase_r;
    rec_pos_nxt    = rec_pos_r;
    unit_cnt_nxt   = unit_cnt_r;
    unit_left_nxt  = unit_left_r;
    sps_nxt        = sps_r;
    pps_nxt        = pps_r;
    rec_err_nxt    = rec_err_r;
    fill_nxt       = fill_r;
    wr_left_nxt    = wr_left_r;
    pkt_phase_nxt  = pkt_phase_r;
    prefix_nxt     = prefix_r;
    nal_rem_nxt    = nal_rem_r;
    first_nxt      = first_r;
    burst_pend_nxt = burst_pend_r;
    wr_start       = 1'b0;
    errc           = ERR_NONE;
    q_push         = 1'b0;
    q_cmd          = '0;
    st_wr          = '0;

    if (burst_done) begin
      burst_pend_nxt = 1'b0;
    end

    if (wr_left_r != 3'd0) begin
      st_wr.en    = 1'b1;
      st_wr.addr  = fill_r;
      st_wr.data  = (wr_left_r == 3'd1) ? 8'd1 : 8'd0;
      fill_nxt    = fill_r + FILL_W'(1);
      wr_left_nxt = wr_left_r - 3'd1;
    end

    if (acc && !in_item.opcode) begin
      unique case (rec_phase_r)
        RP_SKIP: begin
          if (rec_pos_r == 3'd0) begin
            fill_nxt      = '0;
            sps_nxt       = 1'b0;
            pps_nxt       = 1'b0;
            rec_err_nxt   = ERR_NONE;
            unit_cnt_nxt  = '0;
            unit_left_nxt = '0;
          end
          if (rec_pos_r >= 3'd4) begin
            rec_phase_nxt = RP_SPSCNT;
            rec_pos_nxt   = 3'd0;
          end else begin
            rec_pos_nxt = rec_pos_r + 3'd1;
          end
        end
        RP_SPSCNT: begin
          unit_cnt_nxt  = {3'd0, b[4:0]};
          sps_nxt       = (b[4:0] != 5'd0);
          rec_phase_nxt = (b[4:0] != 5'd0) ? RP_LENHI : RP_PPSCNT;
        end
        RP_PPSCNT: begin
          unit_cnt_nxt  = b;
          pps_nxt       = (b != 8'd0);
          rec_pos_nxt   = 3'd1;
          rec_phase_nxt = (b != 8'd0) ? RP_LENHI : RP_DONE;
        end
        RP_LENHI: begin
          unit_left_nxt = {b, 8'd0};
          rec_phase_nxt = RP_LENLO;
        end
        RP_LENLO: begin
          unit_left_nxt = lv;
          if (need > 17'(PSTORE_BYTES)) begin
            rec_err_nxt   = ERR_STORE;
            fill_nxt      = '0;
            rec_phase_nxt = RP_FAIL;
          end else begin
            wr_start = 1'b1;
            if (lv == 16'd0) begin
              unit_cnt_nxt  = cnt_dec;
              rec_phase_nxt = fin_phase;
            end else begin
              rec_phase_nxt = RP_BODY;
            end
          end
        end
        RP_BODY: begin
          if (fill_r < FILL_W'(PSTORE_BYTES)) begin
            st_wr.en   = 1'b1;
            st_wr.addr = fill_r;
            st_wr.data = b;
            fill_nxt   = fill_r + FILL_W'(1);
          end
          unit_left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            unit_cnt_nxt  = cnt_dec;
            rec_phase_nxt = fin_phase;
          end
        end
        RP_DONE, RP_FAIL: begin
        end
        default: begin
        end
      endcase

      if (in_item.last_byte) begin
        if (rec_phase_nxt != RP_DONE && rec_phase_nxt != RP_FAIL) begin
          rec_err_nxt = ERR_UNIT_OVR;
          fill_nxt    = '0;
          wr_start    = 1'b0;
        end
        q_push        = 1'b1;
        q_cmd.op      = CMD_REPORT;
        q_cmd.err     = rec_err_nxt;
        q_cmd.sm      = (rec_err_nxt != ERR_NONE) || !sps_nxt;
        q_cmd.pm      = (rec_err_nxt != ERR_NONE) || !pps_nxt;
        rec_phase_nxt = RP_SKIP;
        rec_pos_nxt   = 3'd0;
        unit_cnt_nxt  = '0;
        unit_left_nxt = '0;
      end

      if (wr_start) begin
        wr_left_nxt = 3'd4;
      end
    end

    if (acc && in_item.opcode) begin
      if (in_item.last_byte) begin
        if (pkt_phase_r != PP_HEAD && pkt_phase_r != PP_BODY) begin
          if (prefix_r < 2'(LEN_BYTES - 1)) begin
            errc = ERR_TRUNC;
          end else if (nal_shift != 32'd0) begin
            errc = ERR_NAL_OVR;
          end
        end else if (nal_rem_r > 32'd1) begin
          errc = ERR_NAL_OVR;
        end
      end

      if (errc != ERR_NONE) begin
        q_push    = 1'b1;
        q_cmd.op  = CMD_PERR;
        q_cmd.err = errc;
        q_cmd.eop = 1'b1;
      end else begin
        priority case (pkt_phase_r)
          PP_HEAD: begin
            q_push        = 1'b1;
            q_cmd.op      = CMD_NAL;
            q_cmd.data    = b;
            q_cmd.long_sc = first_r;
            q_cmd.eop     = in_item.last_byte;
            q_cmd.fill    = (b[4:0] == IDR_TYPE) ? fill_r : '0;
            first_nxt     = 1'b0;
            nal_rem_nxt   = nal_dec;
            pkt_phase_nxt = (nal_dec != 32'd0) ? PP_BODY : PP_LEN;
            if ((b[4:0] == IDR_TYPE) && (fill_r != '0)) begin
              burst_pend_nxt = 1'b1;
            end
          end
          PP_BODY: begin
            q_push      = 1'b1;
            q_cmd.op    = CMD_BYTE;
            q_cmd.data  = b;
            q_cmd.eop   = in_item.last_byte;
            nal_rem_nxt = nal_dec;
            if (nal_dec == 32'd0) begin
              pkt_phase_nxt = PP_LEN;
            end
          end
          default: begin
            pkt_phase_nxt = PP_LEN;
            nal_rem_nxt   = nal_shift;
            if (prefix_r >= 2'(LEN_BYTES - 1)) begin
              prefix_nxt = 2'd0;
              if (nal_shift == 32'd0) begin
                q_push        = 1'b1;
                q_cmd.op      = CMD_SC;
                q_cmd.long_sc = first_r;
                q_cmd.eop     = in_item.last_byte;
                first_nxt     = 1'b0;
              end else begin
                pkt_phase_nxt = PP_HEAD;
              end
            end else begin
              prefix_nxt = prefix_r + 2'd1;
            end
          end
        endcase
      end

      if (in_item.last_byte) begin
        pkt_phase_nxt = PP_LEN;
        prefix_nxt    = 2'd0;
        nal_rem_nxt   = 32'd0;
        first_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_phase_r  <= RP_SKIP;
      rec_pos_r    <= 3'd0;
      unit_cnt_r   <= '0;
      unit_left_r  <= '0;
      sps_r        <= 1'b0;
      pps_r        <= 1'b0;
      rec_err_r    <= ERR_NONE;
      fill_r       <= '0;
      wr_left_r    <= 3'd0;
      pkt_phase_r  <= PP_LEN;
      prefix_r     <= 2'd0;
      nal_rem_r    <= 32'd0;
      first_r      <= 1'b1;
      burst_pend_r <= 1'b0;
    end else begin
      rec_phase_r  <= rec_phase_nxt;
      rec_pos_r    <= rec_pos_nxt;
      unit_cnt_r   <= unit_cnt_nxt;
      unit_left_r  <= unit_left_nxt;
      sps_r        <= sps_nxt;
      pps_r        <= pps_nxt;
      rec_err_r    <= rec_err_nxt;
      fill_r       <= fill_nxt;
      wr_left_r    <= wr_left_nxt;
      pkt_phase_r  <= pkt_phase_nxt;
      prefix_r     <= prefix_nxt;
      nal_rem_r    <= nal_rem_nxt;
      first_r      <= first_nxt;
      burst_pend_r <= burst_pend_nxt;
    end
  end

endmodule

### rtl/a2sc_cmdq.sv
module a2sc_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_push,
  input  a2sc_pkg::cmd_t q_wdata,
  output logic           q_full,
  input  logic           q_pop,
  output a2sc_pkg::cmd_t q_rdata,
  output logic           q_empty
);
  import a2sc_pkg::*;

  cmd_t             slot_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wptr_r, wptr_nxt;
  logic [CQ_AW-1:0] rptr_r, rptr_nxt;
  logic [CQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_full  = (cnt_r == (CQ_AW + 1)'(CQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_rdata = slot_r[rptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + CQ_AW'(1) : wptr_r;
    rptr_nxt = do_pop ? rptr_r + CQ_AW'(1) : rptr_r;
    cnt_nxt  = cnt_r + (CQ_AW + 1)'(do_push) - (CQ_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### rtl/a2sc_back.sv
module a2sc_back #(
  parameter int PSTORE_BYTES = 56
) (
  input  logic                clk,
  input  logic                rst_n,
  input  a2sc_pkg::store_wr_t st_wr,
  input  logic                q_empty,
  input  a2sc_pkg::cmd_t      q_rdata,
  output logic                q_pop,
  output logic                burst_done,
  output logic                empty,
  input  logic                pop,
  output a2sc_pkg::out_item_t out_item
);
  import a2sc_pkg::*;

  localparam int AW = $clog2(PSTORE_BYTES);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_BURST = 2'd1;
  localparam logic [1:0] B_SC    = 2'd2;
  localparam logic [1:0] B_BYTE  = 2'd3;

  logic [7:0]        mem [PSTORE_BYTES];
  logic [7:0]        rdata_r;

  logic [1:0]        state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic [2:0]        sc_left_r, sc_left_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         res_r;
  out_item_t         res;
  logic              out_load;
  logic              step;
  logic [FILL_W-1:0] idx_inc;

  assign step     = !ov_r || pop;
  assign empty    = !ov_r;
  assign out_item = res_r;
  assign idx_inc  = idx_r + FILL_W'(1);

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    idx_nxt     = '0;
    sc_left_nxt = sc_left_r;
    q_pop       = 1'b0;
    burst_done  = 1'b0;
    out_load    = 1'b0;
    res         = '0;

    unique case (state_r)
      B_IDLE: begin
        if (step && !q_empty) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_rdata;
          out_load = 1'b1;
          priority case (q_rdata.op)
            CMD_BYTE: begin
              res.kind          = KIND_STREAM;
              res.out_byte      = q_rdata.data;
              res.end_of_packet = q_rdata.eop;
            end
            CMD_REPORT: begin
              res.kind        = KIND_SETUP;
              res.error_code  = q_rdata.err;
              res.sps_missing = q_rdata.sm;
              res.pps_missing = q_rdata.pm;
            end
            CMD_PERR: begin
              res.kind          = KIND_PERR;
              res.error_code    = q_rdata.err;
              res.end_of_packet = 1'b1;
            end
            CMD_SC: begin
              res.kind    = KIND_STREAM;
              sc_left_nxt = q_rdata.long_sc ? 3'd3 : 3'd2;
              state_nxt   = B_SC;
            end
            CMD_NAL: begin
              res.kind = KIND_STREAM;
              if (q_rdata.fill != '0) begin
                res.out_byte = rdata_r;
                if (q_rdata.fill == FILL_W'(1)) begin
                  burst_done  = 1'b1;
                  sc_left_nxt = q_rdata.long_sc ? 3'd4 : 3'd3;
                  state_nxt   = B_SC;
                end else begin
                  idx_nxt   = FILL_W'(1);
                  state_nxt = B_BURST;
                end
              end else begin
                sc_left_nxt = q_rdata.long_sc ? 3'd3 : 3'd2;
                state_nxt   = B_SC;
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      B_BURST: begin
        if (step) begin
          out_load     = 1'b1;
          res.kind     = KIND_STREAM;
          res.out_byte = rdata_r;
          if (idx_inc == cmd_r.fill) begin
            burst_done  = 1'b1;
            sc_left_nxt = cmd_r.long_sc ? 3'd4 : 3'd3;
            state_nxt   = B_SC;
          end else begin
            idx_nxt = idx_inc;
          end
        end else begin
          idx_nxt = idx_r;
        end
      end
      B_SC: begin
        if (step) begin
          out_load          = 1'b1;
          res.kind          = KIND_STREAM;
          res.out_byte      = (sc_left_r == 3'd1) ? 8'd1 : 8'd0;
          res.end_of_packet = (sc_left_r == 3'd1) && (cmd_r.op == CMD_SC) && cmd_r.eop;
          sc_left_nxt       = sc_left_r - 3'd1;
          if (sc_left_r == 3'd1) begin
            state_nxt = (cmd_r.op == CMD_NAL) ? B_BYTE : B_IDLE;
          end
        end
      end
      B_BYTE: begin
        if (step) begin
          out_load          = 1'b1;
          res.kind          = KIND_STREAM;
          res.out_byte      = cmd_r.data;
          res.end_of_packet = cmd_r.eop;
          state_nxt         = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    if (out_load) begin
      ov_nxt = 1'b1;
    end else if (pop) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_wr.en) begin
      mem[st_wr.addr[AW-1:0]] <= st_wr.data;
    end
    rdata_r <= mem[idx_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (out_load) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      idx_r     <= '0;
      sc_left_r <= 3'd0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      sc_left_r <= sc_left_nxt;
      ov_r      <= ov_nxt;
    end
  end

endmodule

### rtl/avc_length_to_start_code_top.sv
// Throughput: one input byte per cycle for length and body bytes unless full;
//   a NAL's first byte yields 4 or 5 results, plus the stored parameter sets
//   on IDR. The record length-low byte stalls input while a start code is
//   stored; an IDR burst stalls input until the store has been read out (one
//   store byte per cycle while results are popped).
// Reset: synchronous, active low; clears control state, store contents stay.
module avc_length_to_start_code_top #(
  parameter int PSTORE_BYTES = 56
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  a2sc_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output a2sc_pkg::out_item_t out_item
);
  import a2sc_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  cmd_t      q_wdata;
  cmd_t      q_rdata;
  logic      burst_done;
  store_wr_t st_wr;

  a2sc_front #(
    .PSTORE_BYTES(PSTORE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_wdata),
    .burst_done(burst_done),
    .st_wr     (st_wr)
  );

  a2sc_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_wdata(q_wdata),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rdata(q_rdata),
    .q_empty(q_empty)
  );

  a2sc_back #(
    .PSTORE_BYTES(PSTORE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_wr     (st_wr),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .burst_done(burst_done),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

### rtl/a2sc_checker.sv
module a2sc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                empty,
  input logic                pop,
  input a2sc_pkg::out_item_t out_item
);
  import a2sc_pkg::*;

  // hold a waiting result until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting result changed before transfer");

  a_stream_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.kind == KIND_STREAM |->
      out_item.error_code == ERR_NONE && !out_item.sps_missing && !out_item.pps_missing)
    else $error("stream byte carries report fields");

  a_perr: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.kind == KIND_PERR |->
      out_item.end_of_packet &&
      (out_item.error_code == ERR_TRUNC || out_item.error_code == ERR_NAL_OVR))
    else $error("malformed packet error report");

  a_setup: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.kind == KIND_SETUP |->
      !out_item.end_of_packet &&
      (out_item.error_code == ERR_NONE ||
       (out_item.sps_missing && out_item.pps_missing)))
    else $error("malformed setup report");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_item.kind == KIND_STREAM || out_item.kind == KIND_SETUP ||
               out_item.kind == KIND_PERR)
    else $error("undefined result kind");

endmodule

bind avc_length_to_start_code_top a2sc_checker u_a2sc_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .empty   (empty),
  .pop     (pop),
  .out_item(out_item)
);
